/* src/alpha_blend_pixel_clip_core_defines.svh */
// Assertion macros for the alpha blend pixel clip core.
// Used by the port checker; no other dependencies.
`ifndef ALPHA_BLEND_PIXEL_CLIP_CORE_DEFINES_SVH
`define ALPHA_BLEND_PIXEL_CLIP_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define ABPC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abpc check failed");

// next-cycle implication, off during reset
`define ABPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abpc check failed");

// holds in the cycle after a reset cycle
`define ABPC_ASSERT_RESET(name, clk, rst_n, cons) \
    name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("abpc check failed");

`endif

/* src/abpc_pkg.sv */
// Shared constants and types for the alpha blend pixel clip core.
// No dependencies.
package abpc_pkg;

    localparam int unsigned CFG_AW = 5;

    typedef enum logic [2:0] {
        REG_ORIGIN_X       = 3'd0,
        REG_ORIGIN_Y       = 3'd1,
        REG_SURFACE_WIDTH  = 3'd2,
        REG_SURFACE_HEIGHT = 3'd3,
        REG_ROW_STRIDE     = 3'd4
    } abpc_reg_t;

    localparam logic [7:0]  ALPHA_FULL = 8'hFF;
    localparam logic [7:0]  ALPHA_NONE = 8'h00;
    localparam logic [15:0] MIX_ROUND  = 16'd127;

    typedef struct packed {
        logic vis;
        logic full;
    } abpc_flags_t;

endpackage

/* src/abpc_mix.sv */
// One color channel of the source-over blend: products, rounded sum, divide by 255.
// Depends on abpc_pkg.
module abpc_mix import abpc_pkg::*; (
    input  logic       aclk,
    input  logic       en,
    input  logic [7:0] s,
    input  logic [7:0] d,
    input  logic [7:0] a,
    output logic [7:0] q
);

    logic [15:0] sa_reg, sa_next;
    logic [15:0] db_reg, db_next;
    logic [15:0] t_reg, t_next;
    logic [16:0] q_wide;

    always_comb begin
        sa_next = 16'(s) * 16'(a);
        db_next = 16'(d) * 16'(ALPHA_FULL - a);
        // max 255*255+127, fits 16 bits
        t_next  = sa_reg + db_reg + MIX_ROUND;
        // exact t/255 for t below 65535
        q_wide  = 17'(t_reg) + 17'd1 + 17'(t_reg[15:8]);
        q       = q_wide[15:8];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg <= sa_next;
            db_reg <= db_next;
            t_reg  <= t_next;
        end
    end

endmodule

/* src/alpha_blend_pixel_clip_core.sv */
// Channel      | dir | transfer payload
// s_ (stream)  | in  | src_x, src_y, src_pixel, dst_pixel
// m_ (stream)  | out | write_enable (tuser), dest_addr, out_pixel
// apb          | in  | origin_x/y, surface_width/height, row_stride
//
// Four register stages: offset add, clip and multiplies, sums, divide and select.
// One pixel per clock while m_tready does not stall; valid moves through v1, v2, v3 to m_tvalid.
// Throughput is set by the single global stall: all stages advance together.
// aresetn is synchronous, active low; clears valids and loads config defaults.
// A stall on m_tready holds every stage and drops s_tready.
// Top level of the alpha blend pixel clip core; depends on abpc_pkg and abpc_mix.
module alpha_blend_pixel_clip_core import abpc_pkg::*; #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // src_x[11:0], src_y[23:12], src_pixel[55:24], dst_pixel[87:56]
    input  logic [87:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // dest_addr[23:0], out_pixel[55:24]
    output logic [55:0]       m_tdata,
    // write_enable[0]
    output logic              m_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int unsigned BND_W    = (DIM_BITS > 13) ? DIM_BITS : 13;

    logic signed [12:0] origin_x_reg, origin_y_reg;
    logic [BND_W-1:0]   width_reg, height_reg, stride_reg;
    logic               wr_en;
    abpc_reg_t          reg_sel;

    logic               en;
    logic               v1_reg, v2_reg, v3_reg, m_tvalid_reg;
    logic signed [13:0] s1_col_reg, s1_col_next;
    logic signed [13:0] s1_row_reg, s1_row_next;
    logic [31:0]        s1_src_reg, s1_dst_reg;

    abpc_flags_t        s2_flags_reg, s2_flags_next;
    logic [23:0]        s2_prod_reg, s2_prod_next;
    logic [12:0]        s2_col_reg;
    logic [31:0]        s2_src_reg;
    logic [BND_W+12:0]  prod_full;

    abpc_flags_t        s3_flags_reg;
    logic [23:0]        s3_addr_reg, s3_addr_next;
    logic [31:0]        s3_src_reg;

    logic [23:0]        blend;
    logic               m_we_reg;
    logic [23:0]        m_addr_reg, m_addr_next;
    logic [31:0]        m_pixel_reg, m_pixel_next;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = abpc_reg_t'(paddr[CFG_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= BND_W'(MAX_DIM);
            height_reg   <= BND_W'(MAX_DIM);
            stride_reg   <= BND_W'(MAX_DIM);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ORIGIN_X:       origin_x_reg <= pwdata[12:0];
                REG_ORIGIN_Y:       origin_y_reg <= pwdata[12:0];
                REG_SURFACE_WIDTH:  width_reg    <= BND_W'(pwdata[12:0]);
                REG_SURFACE_HEIGHT: height_reg   <= BND_W'(pwdata[12:0]);
                REG_ROW_STRIDE:     stride_reg   <= BND_W'(pwdata[12:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ORIGIN_X:       prdata = 32'(origin_x_reg);
            REG_ORIGIN_Y:       prdata = 32'(origin_y_reg);
            REG_SURFACE_WIDTH:  prdata = 32'(width_reg);
            REG_SURFACE_HEIGHT: prdata = 32'(height_reg);
            REG_ROW_STRIDE:     prdata = 32'(stride_reg);
            default:            prdata = '0;
        endcase
    end

    // pipeline control
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            m_tvalid_reg <= v3_reg;
        end
    end

    // stage 1: target position
    always_comb begin
        s1_col_next = 14'(origin_x_reg) + $signed({2'b00, s_tdata[11:0]});
        s1_row_next = 14'(origin_y_reg) + $signed({2'b00, s_tdata[23:12]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_col_reg <= s1_col_next;
            s1_row_reg <= s1_row_next;
            s1_src_reg <= s_tdata[55:24];
            s1_dst_reg <= s_tdata[87:56];
        end
    end

    // stage 2: clip, row product
    always_comb begin
        s2_flags_next.vis  = !s1_col_reg[13] && !s1_row_reg[13]
                          && (BND_W'(s1_col_reg[12:0]) < width_reg)
                          && (BND_W'(s1_row_reg[12:0]) < height_reg)
                          && (s1_src_reg[31:24] != ALPHA_NONE);
        s2_flags_next.full = (s1_src_reg[31:24] == ALPHA_FULL);
        prod_full          = (BND_W+13)'(s1_row_reg[12:0]) * (BND_W+13)'(stride_reg);
        s2_prod_next       = prod_full[23:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_flags_reg <= s2_flags_next;
            s2_prod_reg  <= s2_prod_next;
            s2_col_reg   <= s1_col_reg[12:0];
            s2_src_reg   <= s1_src_reg;
        end
    end

    // stage 3: address
    assign s3_addr_next = s2_prod_reg + 24'(s2_col_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_flags_reg <= s2_flags_reg;
            s3_addr_reg  <= s3_addr_next;
            s3_src_reg   <= s2_src_reg;
        end
    end

    // color lanes, aligned with stage 3
    for (genvar i = 0; i < 3; i++) begin : g_lane
        abpc_mix u_mix (
            .aclk (aclk),
            .en   (en),
            .s    (s1_src_reg[8*i +: 8]),
            .d    (s1_dst_reg[8*i +: 8]),
            .a    (s1_src_reg[31:24]),
            .q    (blend[8*i +: 8])
        );
    end

    // stage 4: select and output register
    always_comb begin
        m_addr_next  = '0;
        m_pixel_next = '0;
        if (s3_flags_reg.vis) begin
            m_addr_next  = s3_addr_reg;
            m_pixel_next = s3_flags_reg.full ? s3_src_reg : {ALPHA_FULL, blend};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_we_reg    <= s3_flags_reg.vis;
            m_addr_reg  <= m_addr_next;
            m_pixel_reg <= m_pixel_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_we_reg;
    assign m_tdata  = {m_pixel_reg, m_addr_reg};

endmodule

/* src/abpc_check.sv */
// Port checker for the alpha blend pixel clip core, bound to the top level.
// Depends on alpha_blend_pixel_clip_core_defines.svh.
`include "alpha_blend_pixel_clip_core_defines.svh"

module abpc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    `ABPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ABPC_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ABPC_ASSERT_IMP(a_nowrite_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == 56'd0)
    `ABPC_ASSERT_IMP(a_write_opaque, aclk, aresetn, m_tvalid && m_tuser, m_tdata[55:48] == 8'hFF)
    `ABPC_ASSERT_RESET(a_reset_idle, aclk, aresetn, !m_tvalid)

endmodule

bind alpha_blend_pixel_clip_core abpc_check u_abpc_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_alpha_blend_pixel_clip_core.sv */
// Self-checking testbench for alpha_blend_pixel_clip_core: source-over blend, clipping and
// destination addressing, checked against an in-bench pixel predictor under random flow control.
// Depends on abpc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_alpha_blend_pixel_clip_core;
    import abpc_pkg::*;

    localparam int REG_SPARE      = 5;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_PIXELS   = 60;

    localparam int RX_ALWAYS   = 0;
    localparam int RX_HALF     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] src;
        logic [31:0] dst;
    } pixel_in_t;

    typedef struct packed {
        logic        we;
        logic [23:0] addr;
        logic [31:0] pixel;
    } blend_out_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [87:0]       s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;
    logic              m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [CFG_AW-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // shadow copy of the surface registers
    logic signed [12:0] org_x        = 13'sd0;
    logic signed [12:0] org_y        = 13'sd0;
    logic [12:0]        surf_w       = 13'd4096;
    logic [12:0]        surf_h       = 13'd4096;
    logic [12:0]        stride_words = 13'd4096;

    blend_out_t expected_blends[$];
    blend_out_t head_blend;

    int fail_count    = 0;
    int pixels_sent   = 0;
    int results_seen  = 0;
    int writes_seen   = 0;
    int reg_writes    = 0;
    int input_stalls  = 0;
    int burst_left    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mode_left     = 0;
    int rx_mode       = RX_ALWAYS;
    int quiet_cycles  = 0;
    int cycle_count   = 0;

    alpha_blend_pixel_clip_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                               input logic [7:0] a);
        int sv;
        int dv;
        int av;
        sv = s;
        dv = d;
        av = a;
        return 8'((sv * av + dv * (255 - av) + int'(MIX_ROUND)) / 255);
    endfunction

    function automatic blend_out_t predict_blend(input pixel_in_t px);
        int         col;
        int         row;
        int         ox;
        int         oy;
        int         w;
        int         h;
        longint     lin;
        logic [7:0] a;
        blend_out_t r;
        ox  = org_x;
        oy  = org_y;
        w   = surf_w;
        h   = surf_h;
        col = px.x;
        row = px.y;
        col = col + ox;
        row = row + oy;
        a   = px.src[31:24];
        r   = '0;
        if (col < 0 || col >= w || row < 0 || row >= h || a == ALPHA_NONE)
            return r;
        lin     = longint'(row) * longint'(stride_words) + longint'(col);
        r.we    = 1'b1;
        r.addr  = lin[23:0];
        if (a == ALPHA_FULL) begin
            r.pixel = px.src;
        end else begin
            r.pixel = {ALPHA_FULL,
                       mix_channel(px.src[23:16], px.dst[23:16], a),
                       mix_channel(px.src[15:8], px.dst[15:8], a),
                       mix_channel(px.src[7:0], px.dst[7:0], a)};
        end
        return r;
    endfunction

    function automatic pixel_in_t mk_pixel(input logic [11:0] x, input logic [11:0] y,
                                           input logic [31:0] src, input logic [31:0] dst);
        pixel_in_t px;
        px.x   = x;
        px.y   = y;
        px.src = src;
        px.dst = dst;
        return px;
    endfunction

    // pick an image coordinate that mostly lands on or just beside the surface
    function automatic logic [11:0] aim_coord(input int origin, input int extent);
        int t;
        if ($urandom_range(0, 3) == 0 || extent == 0)
            return 12'($urandom);
        t = int'($urandom_range(0, extent + 1)) - 1 - origin;
        if (t < 0 || t > 4095)
            return 12'($urandom);
        return 12'(t);
    endfunction

    function automatic pixel_in_t random_pixel();
        pixel_in_t  px;
        logic [7:0] a;
        px.x   = aim_coord(int'(org_x), int'(surf_w));
        px.y   = aim_coord(int'(org_y), int'(surf_h));
        px.src = $urandom;
        px.dst = $urandom;
        case ($urandom_range(0, 9))
            0, 1:    a = ALPHA_NONE;
            2, 3:    a = ALPHA_FULL;
            4:       a = $urandom_range(0, 1) ? 8'd1 : 8'd254;
            default: a = 8'($urandom_range(1, 254));
        endcase
        px.src[31:24] = a;
        return px;
    endfunction

    task automatic send_pixel(input pixel_in_t px);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {px.dst, px.src, px.y, px.x};
        do @(posedge aclk); while (!s_tready);
        expected_blends.push_back(predict_blend(px));
        pixels_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_blends.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx * 4);
        pwdata  <= {19'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIGIN_X:       org_x        = value;
            REG_ORIGIN_Y:       org_y        = value;
            REG_SURFACE_WIDTH:  surf_w       = value;
            REG_SURFACE_HEIGHT: surf_h       = value;
            REG_ROW_STRIDE:     stride_words = value;
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_surface(input int ox, input int oy, input int w, input int h,
                               input int stride);
        wait_idle();
        write_reg(REG_ORIGIN_X, 13'(ox));
        write_reg(REG_ORIGIN_Y, 13'(oy));
        write_reg(REG_SURFACE_WIDTH, 13'(w));
        write_reg(REG_SURFACE_HEIGHT, 13'(h));
        write_reg(REG_ROW_STRIDE, 13'(stride));
    endtask

    task automatic test_blend_modes();
        // reset surface: copy, blend, transparent, alpha extremes, max address
        send_pixel(mk_pixel(12'd0, 12'd0, 32'hFF102030, 32'h12345678));
        send_pixel(mk_pixel(12'd4095, 12'd4095, 32'h80FFFFFF, 32'h00000000));
        send_pixel(mk_pixel(12'd100, 12'd7, 32'h00ABCDEF, 32'hFFFFFFFF));
        send_pixel(mk_pixel(12'd1, 12'd1, 32'h01FFFFFF, 32'h00000000));
        send_pixel(mk_pixel(12'd2, 12'd3, 32'hFE000000, 32'hFFFFFFFF));
        send_pixel(mk_pixel(12'd4095, 12'd0, 32'hFFFFFFFF, 32'h00000000));
        send_pixel(mk_pixel(12'd0, 12'd4095, 32'h7F00FF00, 32'h00FF00FF));
    endtask

    task automatic test_clip_bounds();
        // negative origin, width above the nominal maximum, single row, zero stride
        set_surface(-1, -1, 8191, 1, 0);
        send_pixel(mk_pixel(12'd0, 12'd1, 32'hFF000001, 32'h0));
        send_pixel(mk_pixel(12'd1, 12'd1, 32'hFF000002, 32'h0));
        send_pixel(mk_pixel(12'd4095, 12'd1, 32'h40C08040, 32'h80808080));
        send_pixel(mk_pixel(12'd5, 12'd2, 32'hFF000003, 32'h0));
        send_pixel(mk_pixel(12'd5, 12'd0, 32'hFF000004, 32'h0));
        // empty surface in either direction
        set_surface(0, 0, 0, 4096, 4096);
        send_pixel(mk_pixel(12'd0, 12'd0, 32'hFFFFFFFF, 32'h0));
        set_surface(0, 0, 4096, 0, 4096);
        send_pixel(mk_pixel(12'd0, 12'd0, 32'hFFFFFFFF, 32'h0));
        // largest origin and stride: address wraps
        set_surface(4095, 4095, 8191, 8191, 8191);
        send_pixel(mk_pixel(12'd0, 12'd0, 32'hFFA5A5A5, 32'h0));
        send_pixel(mk_pixel(12'd4095, 12'd4095, 32'hC0123456, 32'hFEDCBA98));
        // most negative origin: right edge lands one left of the surface
        set_surface(-4096, -4096, 4096, 4096, 1);
        send_pixel(mk_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF, 32'h0));
    endtask

    task automatic test_spare_register();
        set_surface(3, 2, 64, 64, 80);
        wait_idle();
        write_reg(REG_SPARE, 13'h1ABC);
        send_pixel(mk_pixel(12'd10, 12'd20, 32'h9933CC66, 32'h11223344));
    endtask

    task automatic test_random_stream();
        int phase;
        int w;
        int h;
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 0) begin
                set_surface(0, 0, 4096, 4096, 4096);
            end else if (phase % 2 == 1) begin
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 64);
                set_surface(int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 64)) - 32,
                            w, h, w + int'($urandom_range(0, 8)));
            end else begin
                set_surface($urandom, $urandom, $urandom, $urandom, $urandom);
            end
            repeat (PHASE_PIXELS) send_pixel(random_pixel());
        end
    endtask

    task automatic test_output_backpressure();
        set_surface(-8, 4, 40, 30, 48);
        hold_requests++;
        repeat (48) send_pixel(random_pixel());
    endtask

    // result receiver: changing ready pattern, plus long hold-offs on request
    always @(posedge aclk) begin
        cycle_count++;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(RX_ALWAYS, RX_PERIODIC);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_HALF:     m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_tready <= (cycle_count % 5 != 0);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_blends.size() == 0) begin
                $error("unexpected result transfer: write_enable=%0b dest_addr=%h out_pixel=%h",
                       m_tuser, m_tdata[23:0], m_tdata[55:24]);
                fail_count++;
            end else begin
                head_blend = expected_blends.pop_front();
                if (head_blend.we)
                    writes_seen++;
                if (m_tuser !== head_blend.we) begin
                    $error("write_enable: expected %0b, got %0b", head_blend.we, m_tuser);
                    fail_count++;
                end
                if (m_tdata[23:0] !== head_blend.addr) begin
                    $error("dest_addr: expected %h, got %h", head_blend.addr, m_tdata[23:0]);
                    fail_count++;
                end
                if (m_tdata[55:24] !== head_blend.pixel) begin
                    $error("out_pixel: expected %h, got %h", head_blend.pixel, m_tdata[55:24]);
                    fail_count++;
                end
            end
        end
        if (aresetn && s_tvalid && !s_tready)
            input_stalls++;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb_alpha_blend_pixel_clip_core NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_blend_modes();
        test_clip_bounds();
        test_spare_register();
        test_random_stream();
        test_output_backpressure();
        wait_idle();
        $display("Run: %0d pixels in, %0d results (%0d writes), %0d register writes",
                 pixels_sent, results_seen, writes_seen, reg_writes);
        $display("Input stalled for %0d cycles under output backpressure", input_stalls);
        if (fail_count == 0 && expected_blends.size() == 0)
            $display("tb_alpha_blend_pixel_clip_core OK");
        else
            $display("tb_alpha_blend_pixel_clip_core NOT OK");
        $finish;
    end

endmodule
